>>> src/assert_macros.svh
// assertion macros for the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define KF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("kf1d assertion failed");

// next-cycle implication, disabled during reset
`define KF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("kf1d assertion failed");

`endif

>>> src/kf1d_pkg.sv
// ----------------------------------------------------------------------------
// kf1d_pkg
// Types, constants and saturation helper for the 1-D constant-velocity filter.
// ----------------------------------------------------------------------------
package kf1d_pkg;

	localparam int FRAC_BITS = 16;

	localparam int VAL_W  = 32;
	localparam int PROD_W = 64;
	localparam int SUM_W  = 67;
	localparam int S_W    = 33;
	localparam int CNT_W  = 6;

	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fffffff;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh80000000;

	// initial variance 1000.0, clamped for wide fractions
	localparam longint VAR_INIT_L = 64'sd1000 <<< FRAC_BITS;
	localparam logic signed [VAL_W-1:0] VAR_RESET =
		(VAR_INIT_L > 64'sd2147483647) ? VAL_MAX : VAL_W'(VAR_INIT_L);
	localparam logic [30:0] R_RESET = 31'(64'd1 << FRAC_BITS);

	typedef enum logic [2:0] {
		CFG_MEAS_NOISE_VAR   = 3'd0,
		CFG_PROC_NOISE_POS   = 3'd1,
		CFG_PROC_NOISE_CROSS = 3'd2,
		CFG_PROC_NOISE_VEL   = 3'd3,
		CFG_MOTION_POS       = 3'd4,
		CFG_MOTION_VEL       = 3'd5
	} cfg_reg_t;

	// one correction quotient per operation, in this order
	typedef enum logic [2:0] {
		OP_X0  = 3'd0,
		OP_X1  = 3'd1,
		OP_P00 = 3'd2,
		OP_P01 = 3'd3,
		OP_P11 = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_CHECK,
		ST_MUL,
		ST_DINIT,
		ST_DIV,
		ST_ACC,
		ST_PRED
	} state_t;

	typedef struct packed {
		logic take;
		logic load;
		logic check;
		logic mul;
		logic div_init;
		logic div_step;
		logic acc;
		logic pred;
		op_t  op;
	} dp_cmd_t;

	typedef struct packed {
		logic s_pos;
		logic div_last;
		logic out_busy;
	} dp_stat_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] val;
		logic                    ovf;
	} sat_t;

	function automatic sat_t sat32(input logic signed [SUM_W-1:0] v);
		sat_t r;
		if (v > SUM_W'(VAL_MAX)) begin
			r.val = VAL_MAX;
			r.ovf = 1'b1;
		end else if (v < SUM_W'(VAL_MIN)) begin
			r.val = VAL_MIN;
			r.ovf = 1'b1;
		end else begin
			r.val = VAL_W'(v);
			r.ovf = 1'b0;
		end
		return r;
	endfunction

endpackage

>>> src/kf1d_if.sv
// ----------------------------------------------------------------------------
// kf1d_if
// Valid/ready channels for measurements in and estimates out.
// ----------------------------------------------------------------------------
interface kf1d_meas_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] measurement;

	modport source (output valid, output measurement, input ready);
	modport sink (input valid, input measurement, output ready);
endinterface

interface kf1d_est_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_out;
	logic signed [31:0] vel_out;
	logic signed [31:0] var_pos_out;
	logic signed [31:0] cov_cross_out;
	logic signed [31:0] var_vel_out;
	logic               fault;

	modport source (output valid, output pos_out, output vel_out, output var_pos_out,
		output cov_cross_out, output var_vel_out, output fault, input ready);
	modport sink (input valid, input pos_out, input vel_out, input var_pos_out,
		input cov_cross_out, input var_vel_out, input fault, output ready);
endinterface

>>> src/kalman_filter_1d_const_velocity_top.sv
// ----------------------------------------------------------------------------
// kalman_filter_1d_const_velocity_top
// Two-state fixed-point Kalman filter, one position measurement per transfer.
// ----------------------------------------------------------------------------
// update: five quotients when S > 0, none when S <= 0, then the prediction
// each quotient: a multiply, a divider setup, 64 divider steps and an accumulate
// one measurement at a time; the divider makes one quotient bit per cycle, and
// a finished result may wait in the output register while the next item runs
// reset: async active low, state and covariance to initial values, r = 1.0
module kalman_filter_1d_const_velocity_top (
	input  logic              clk,
	input  logic              arst_n,
	kf1d_meas_if.sink         meas,
	kf1d_est_if.source        est,
	input  logic              cfg_wen,
	input  logic [2:0]        cfg_idx,
	input  logic [31:0]       cfg_data
);

	kf1d_pkg::dp_cmd_t  cmd;
	kf1d_pkg::dp_stat_t stat;

	kf1d_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (meas.valid),
		.in_ready (meas.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	kf1d_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_idx       (cfg_idx),
		.cfg_data      (cfg_data),
		.measurement   (meas.measurement),
		.cmd           (cmd),
		.stat          (stat),
		.out_ready     (est.ready),
		.out_valid     (est.valid),
		.pos_out       (est.pos_out),
		.vel_out       (est.vel_out),
		.var_pos_out   (est.var_pos_out),
		.cov_cross_out (est.cov_cross_out),
		.var_vel_out   (est.var_vel_out),
		.fault         (est.fault)
	);

endmodule

>>> src/kf1d_ctrl.sv
// ----------------------------------------------------------------------------
// kf1d_ctrl
// Sequencer: update quotients one at a time (none when S is not positive), then prediction.
// ----------------------------------------------------------------------------
module kf1d_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  kf1d_pkg::dp_stat_t  stat,
	output kf1d_pkg::dp_cmd_t   cmd
);

	kf1d_pkg::state_t state_q, state_n;
	kf1d_pkg::op_t    op_q, op_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kf1d_pkg::ST_IDLE;
			op_q    <= kf1d_pkg::OP_X0;
		end else begin
			state_q <= state_n;
			op_q    <= op_n;
		end
	end

	always_comb begin
		state_n  = state_q;
		op_n     = op_q;
		cmd      = '0;
		cmd.op   = op_q;
		in_ready = 1'b0;
		unique case (state_q)
			kf1d_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_n  = kf1d_pkg::ST_LOAD;
				end
			end
			kf1d_pkg::ST_LOAD: begin
				cmd.load = 1'b1;
				state_n  = kf1d_pkg::ST_CHECK;
			end
			kf1d_pkg::ST_CHECK: begin
				cmd.check = 1'b1;
				op_n      = kf1d_pkg::OP_X0;
				state_n   = stat.s_pos ? kf1d_pkg::ST_MUL : kf1d_pkg::ST_PRED;
			end
			kf1d_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_n = kf1d_pkg::ST_DINIT;
			end
			kf1d_pkg::ST_DINIT: begin
				cmd.div_init = 1'b1;
				state_n      = kf1d_pkg::ST_DIV;
			end
			kf1d_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_n = kf1d_pkg::ST_ACC;
				end
			end
			kf1d_pkg::ST_ACC: begin
				cmd.acc = 1'b1;
				unique case (op_q)
					kf1d_pkg::OP_X0:  op_n = kf1d_pkg::OP_X1;
					kf1d_pkg::OP_X1:  op_n = kf1d_pkg::OP_P00;
					kf1d_pkg::OP_P00: op_n = kf1d_pkg::OP_P01;
					kf1d_pkg::OP_P01: op_n = kf1d_pkg::OP_P11;
					default:          op_n = kf1d_pkg::OP_X0;
				endcase
				state_n = (op_q == kf1d_pkg::OP_P11) ? kf1d_pkg::ST_PRED : kf1d_pkg::ST_MUL;
			end
			kf1d_pkg::ST_PRED: begin
				// wait for the previous result to be taken
				if (!stat.out_busy) begin
					cmd.pred = 1'b1;
					state_n  = kf1d_pkg::ST_IDLE;
				end
			end
			default: state_n = kf1d_pkg::ST_IDLE;
		endcase
	end

endmodule

>>> src/kf1d_dp.sv
// ----------------------------------------------------------------------------
// kf1d_dp
// State, config registers, multiplier, serial divider and result register.
// ----------------------------------------------------------------------------
module kf1d_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wen,
	input  logic [2:0]                cfg_idx,
	input  logic [31:0]               cfg_data,
	input  logic signed [31:0]        measurement,
	input  kf1d_pkg::dp_cmd_t         cmd,
	output kf1d_pkg::dp_stat_t        stat,
	input  logic                      out_ready,
	output logic                      out_valid,
	output logic signed [31:0]        pos_out,
	output logic signed [31:0]        vel_out,
	output logic signed [31:0]        var_pos_out,
	output logic signed [31:0]        cov_cross_out,
	output logic signed [31:0]        var_vel_out,
	output logic                      fault
);

	localparam int VW = kf1d_pkg::VAL_W;
	localparam int PW = kf1d_pkg::PROD_W;
	localparam int SW = kf1d_pkg::SUM_W;

	// config
	logic [30:0]          r_q, q00_q, q11_q;
	logic signed [VW-1:0] q01_q, u0_q, u1_q;

	// filter state
	logic signed [VW-1:0] x0_q, x1_q, p00_q, p01_q, p11_q;
	// updated values feeding the prediction
	logic signed [VW-1:0] ux0_q, ux1_q, up00_q, up01_q, up11_q;

	logic signed [VW-1:0]            z_q, y_q;
	logic signed [kf1d_pkg::S_W-1:0] s_q;
	logic                            fault_q;
	logic signed [PW-1:0]            prod_q;

	// divider
	logic [PW-1:0]                 div_q;
	logic [kf1d_pkg::S_W-1:0]      rem_q;
	logic [kf1d_pkg::CNT_W-1:0]    cnt_q;
	logic                          neg_q;
	logic [kf1d_pkg::S_W:0]        trial;
	logic [kf1d_pkg::S_W:0]        dvs;
	logic                          fits;
	logic signed [PW-1:0]          quo;

	logic signed [VW-1:0] mul_a, mul_b, base;
	logic signed [SW-1:0] acc_sum;
	kf1d_pkg::sat_t       acc_sat, y_sat;
	kf1d_pkg::sat_t       nx0, nx1, n00, n01, n11;
	logic                 out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q   <= kf1d_pkg::R_RESET;
			q00_q <= '0;
			q01_q <= '0;
			q11_q <= '0;
			u0_q  <= '0;
			u1_q  <= '0;
		end else if (cfg_wen) begin
			unique case (kf1d_pkg::cfg_reg_t'(cfg_idx))
				kf1d_pkg::CFG_MEAS_NOISE_VAR:   r_q   <= cfg_data[30:0];
				kf1d_pkg::CFG_PROC_NOISE_POS:   q00_q <= cfg_data[30:0];
				kf1d_pkg::CFG_PROC_NOISE_CROSS: q01_q <= cfg_data;
				kf1d_pkg::CFG_PROC_NOISE_VEL:   q11_q <= cfg_data[30:0];
				kf1d_pkg::CFG_MOTION_POS:       u0_q  <= cfg_data;
				kf1d_pkg::CFG_MOTION_VEL:       u1_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// operand and base selection for the update quotients
	always_comb begin
		unique case (cmd.op)
			kf1d_pkg::OP_X0:  begin mul_a = p00_q; mul_b = y_q;   base = x0_q;  end
			kf1d_pkg::OP_X1:  begin mul_a = p01_q; mul_b = y_q;   base = x1_q;  end
			kf1d_pkg::OP_P00: begin mul_a = p00_q; mul_b = p00_q; base = p00_q; end
			kf1d_pkg::OP_P01: begin mul_a = p00_q; mul_b = p01_q; base = p01_q; end
			kf1d_pkg::OP_P11: begin mul_a = p01_q; mul_b = p01_q; base = p11_q; end
			default:          begin mul_a = '0;    mul_b = '0;    base = '0;    end
		endcase
	end

	assign dvs   = {1'b0, s_q};
	assign trial = {rem_q, div_q[PW-1]};
	assign fits  = trial >= dvs;
	assign quo   = neg_q ? -$signed(div_q) : $signed(div_q);

	// state updates add the quotient, covariance updates subtract it
	always_comb begin
		if (cmd.op == kf1d_pkg::OP_X0 || cmd.op == kf1d_pkg::OP_X1) begin
			acc_sum = SW'(base) + SW'(quo);
		end else begin
			acc_sum = SW'(base) - SW'(quo);
		end
		acc_sat = kf1d_pkg::sat32(acc_sum);
		y_sat   = kf1d_pkg::sat32(SW'(z_q) - SW'(x0_q));
		nx0 = kf1d_pkg::sat32(SW'(ux0_q) + SW'(ux1_q) + SW'(u0_q));
		nx1 = kf1d_pkg::sat32(SW'(ux1_q) + SW'(u1_q));
		n00 = kf1d_pkg::sat32(SW'(up00_q) + (SW'(up01_q) <<< 1) + SW'(up11_q)
			+ SW'({1'b0, q00_q}));
		n01 = kf1d_pkg::sat32(SW'(up01_q) + SW'(up11_q) + SW'(q01_q));
		n11 = kf1d_pkg::sat32(SW'(up11_q) + SW'({1'b0, q11_q}));
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			z_q <= measurement;
		end
		if (cmd.load) begin
			s_q    <= kf1d_pkg::S_W'(p00_q) + kf1d_pkg::S_W'({1'b0, r_q});
			ux0_q  <= x0_q;
			ux1_q  <= x1_q;
			up00_q <= p00_q;
			up01_q <= p01_q;
			up11_q <= p11_q;
		end
		if (cmd.check) begin
			y_q <= y_sat.val;
		end
		if (cmd.mul) begin
			prod_q <= PW'(mul_a) * PW'(mul_b);
		end
		if (cmd.div_init) begin
			div_q <= prod_q[PW-1] ? PW'(-prod_q) : PW'(prod_q);
			neg_q <= prod_q[PW-1];
			rem_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= fits ? kf1d_pkg::S_W'(trial - dvs) : kf1d_pkg::S_W'(trial);
			div_q <= {div_q[PW-2:0], fits};
		end
		if (cmd.acc) begin
			unique case (cmd.op)
				kf1d_pkg::OP_X0:  ux0_q  <= acc_sat.val;
				kf1d_pkg::OP_X1:  ux1_q  <= acc_sat.val;
				kf1d_pkg::OP_P00: up00_q <= acc_sat.val;
				kf1d_pkg::OP_P01: up01_q <= acc_sat.val;
				kf1d_pkg::OP_P11: up11_q <= acc_sat.val;
				default: ;
			endcase
		end
		if (cmd.pred) begin
			pos_out       <= nx0.val;
			vel_out       <= nx1.val;
			var_pos_out   <= n00.val;
			cov_cross_out <= n01.val;
			var_vel_out   <= n11.val;
			fault         <= fault_q | nx0.ovf | nx1.ovf | n00.ovf | n01.ovf | n11.ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x0_q        <= '0;
			x1_q        <= '0;
			p00_q       <= kf1d_pkg::VAR_RESET;
			p01_q       <= '0;
			p11_q       <= kf1d_pkg::VAR_RESET;
			fault_q     <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				fault_q <= 1'b0;
			end else if (cmd.check) begin
				fault_q <= stat.s_pos ? y_sat.ovf : 1'b1;
			end else if (cmd.acc) begin
				fault_q <= fault_q | acc_sat.ovf;
			end
			if (cmd.div_init) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.pred) begin
				x0_q        <= nx0.val;
				x1_q        <= nx1.val;
				p00_q       <= n00.val;
				p01_q       <= n01.val;
				p11_q       <= n11.val;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.s_pos    = !s_q[kf1d_pkg::S_W-1] && (s_q != '0);
	assign stat.div_last = (cnt_q == {kf1d_pkg::CNT_W{1'b1}});
	assign stat.out_busy = out_valid_q;
	assign out_valid     = out_valid_q;

endmodule

>>> src/kf1d_chk.sv
// ----------------------------------------------------------------------------
// kf1d_chk
// Port-level checks on the filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kf1d_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] pos_out,
	input logic [31:0] vel_out,
	input logic [31:0] var_pos_out,
	input logic [31:0] cov_cross_out,
	input logic [31:0] var_vel_out,
	input logic        fault
);

	// only one item in flight
	`KF_ASSERT_NEXT(a_busy_after_take, clk, arst_n, in_valid && in_ready, !in_ready)

	// a result appears only out of a busy period
	`KF_ASSERT_NOW(a_result_from_busy, clk, arst_n, $rose(out_valid), !$past(in_ready))

	// no input transfer in the cycle before a new result appears
	`KF_ASSERT_NOW(a_no_take_on_result, clk, arst_n, $rose(out_valid),
		!$past(in_valid && in_ready))

	// stalled result holds
	`KF_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable({pos_out, vel_out, var_pos_out, cov_cross_out,
		var_vel_out, fault}))

endmodule

bind kalman_filter_1d_const_velocity_top kf1d_chk u_kf1d_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (meas.valid),
	.in_ready      (meas.ready),
	.out_valid     (est.valid),
	.out_ready     (est.ready),
	.pos_out       (est.pos_out),
	.vel_out       (est.vel_out),
	.var_pos_out   (est.var_pos_out),
	.cov_cross_out (est.cov_cross_out),
	.var_vel_out   (est.var_vel_out),
	.fault         (est.fault)
);

>>> bench/tb_kalman_filter_1d_const_velocity_top.sv
// ----------------------------------------------------------------------------
// tb_kalman_filter_1d_const_velocity_top
// Self-checking bench for the 1-D constant-velocity filter. Measurements are
// streamed over the input channel with random gaps. A bit-exact fixed-point
// filter model inside the bench predicts each estimate, and the output
// monitor compares every field. Noise and motion registers are rewritten
// between phases, the extreme values among them.
// ----------------------------------------------------------------------------
module tb_kalman_filter_1d_const_velocity_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint CYCLE_LIMIT = 3000000;
	localparam int     DRAIN_WAIT  = 400;
	localparam logic [2:0] CFG_SPARE_LO = 3'd6;
	localparam logic [2:0] CFG_SPARE_HI = 3'd7;

	typedef struct {
		logic signed [31:0] pos;
		logic signed [31:0] vel;
		logic signed [31:0] var_pos;
		logic signed [31:0] cov_cross;
		logic signed [31:0] var_vel;
		logic               fault;
	} estimate_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wen;
	logic [2:0]  cfg_idx;
	logic [31:0] cfg_data;

	kf1d_meas_if meas_ch();
	kf1d_est_if  est_ch();

	kalman_filter_1d_const_velocity_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.meas     (meas_ch),
		.est      (est_ch),
		.cfg_wen  (cfg_wen),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	// filter model state and register shadow
	longint est_pos, est_vel, est_var_pos, est_cov_cross, est_var_vel;
	longint r_meas, q_pos, q_cross, q_vel, u_pos, u_vel;

	estimate_t expected_q[$];
	int        n_errors;
	int        n_meas;
	int        n_estimates;
	int        n_faults;
	longint    cycle_cnt;
	bit        sender_idle_en;
	bit        receiver_idle_en;
	int        hold_req;
	int        hold_left;

	// tracked target for realistic measurement sequences
	longint track_pos, track_vel;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint clamp32(input longint v, inout bit f);
		if (v > 64'sd2147483647) begin
			f = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			f = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// measurement update followed by prediction, bit exact
	function automatic estimate_t filter_step(input logic signed [31:0] z);
		estimate_t e;
		bit        f;
		longint    s, y, x0, x1, p00, p01, p11, n00, n01, n11;
		f = 1'b0;
		x0 = est_pos;
		x1 = est_vel;
		p00 = est_var_pos;
		p01 = est_cov_cross;
		p11 = est_var_vel;
		s = p00 + r_meas;
		if (s > 0) begin
			y = clamp32(longint'(z) - x0, f);
			x0 = clamp32(x0 + (p00 * y) / s, f);
			x1 = clamp32(x1 + (p01 * y) / s, f);
			n00 = clamp32(p00 - (p00 * p00) / s, f);
			n01 = clamp32(p01 - (p00 * p01) / s, f);
			n11 = clamp32(p11 - (p01 * p01) / s, f);
			p00 = n00;
			p01 = n01;
			p11 = n11;
		end else begin
			f = 1'b1;
		end
		x0 = clamp32(x0 + x1 + u_pos, f);
		x1 = clamp32(x1 + u_vel, f);
		n00 = clamp32(p00 + 2 * p01 + p11 + q_pos, f);
		n01 = clamp32(p01 + p11 + q_cross, f);
		n11 = clamp32(p11 + q_vel, f);
		est_pos = x0;
		est_vel = x1;
		est_var_pos = n00;
		est_cov_cross = n01;
		est_var_vel = n11;
		e.pos = x0[31:0];
		e.vel = x1[31:0];
		e.var_pos = n00[31:0];
		e.cov_cross = n01[31:0];
		e.var_vel = n11[31:0];
		e.fault = f;
		return e;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		n_errors++;
		$display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
	endtask

	// cycle budget
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d estimates pending", cycle_cnt,
				expected_q.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// estimate receiver: random stalls plus one long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_ch.ready <= 1'b0;
			hold_left = 0;
		end else begin
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				est_ch.ready <= 1'b0;
			end else if (receiver_idle_en) begin
				est_ch.ready <= ($urandom_range(99) >= 36);
			end else begin
				est_ch.ready <= 1'b1;
			end
		end
	end

	// estimate checker
	always @(posedge clk) begin
		estimate_t w;
		if (arst_n && est_ch.valid && est_ch.ready) begin
			n_estimates++;
			if (expected_q.size() == 0) begin
				n_errors++;
				$display("[%0t] estimate transfer with nothing expected", $realtime);
			end else begin
				w = expected_q.pop_front();
				if (w.fault) n_faults++;
				if (est_ch.pos_out !== w.pos)
					report_mismatch("pos_out", est_ch.pos_out, w.pos);
				if (est_ch.vel_out !== w.vel)
					report_mismatch("vel_out", est_ch.vel_out, w.vel);
				if (est_ch.var_pos_out !== w.var_pos)
					report_mismatch("var_pos_out", est_ch.var_pos_out, w.var_pos);
				if (est_ch.cov_cross_out !== w.cov_cross)
					report_mismatch("cov_cross_out", est_ch.cov_cross_out, w.cov_cross);
				if (est_ch.var_vel_out !== w.var_vel)
					report_mismatch("var_vel_out", est_ch.var_vel_out, w.var_vel);
				if (est_ch.fault !== w.fault)
					report_mismatch("fault", est_ch.fault, w.fault);
			end
		end
	end

	task automatic send_meas(input logic signed [31:0] z);
		// valid may still be high from the previous transfer; lower it only for a gap
		while (sender_idle_en && $urandom_range(99) < 36) begin
			meas_ch.valid <= 1'b0;
			@(posedge clk);
		end
		meas_ch.valid <= 1'b1;
		meas_ch.measurement <= z;
		do @(posedge clk); while (!meas_ch.ready);
		n_meas++;
		expected_q.insert(expected_q.size(), filter_step(z));
	endtask

	task automatic wait_idle();
		meas_ch.valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
		cfg_wen <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_wen <= 1'b0;
		@(posedge clk);
		case (idx)
			kf1d_pkg::CFG_MEAS_NOISE_VAR:   r_meas = longint'(data[30:0]);
			kf1d_pkg::CFG_PROC_NOISE_POS:   q_pos = longint'(data[30:0]);
			kf1d_pkg::CFG_PROC_NOISE_CROSS: q_cross = longint'($signed(data));
			kf1d_pkg::CFG_PROC_NOISE_VEL:   q_vel = longint'(data[30:0]);
			kf1d_pkg::CFG_MOTION_POS:       u_pos = longint'($signed(data));
			kf1d_pkg::CFG_MOTION_VEL:       u_vel = longint'($signed(data));
			default: ;
		endcase
	endtask

	task automatic cfg_all(input logic [31:0] r, input logic [31:0] qp, input logic [31:0] qc,
		input logic [31:0] qv, input logic [31:0] up, input logic [31:0] uv);
		cfg_write(kf1d_pkg::CFG_MEAS_NOISE_VAR, r);
		cfg_write(kf1d_pkg::CFG_PROC_NOISE_POS, qp);
		cfg_write(kf1d_pkg::CFG_PROC_NOISE_CROSS, qc);
		cfg_write(kf1d_pkg::CFG_PROC_NOISE_VEL, qv);
		cfg_write(kf1d_pkg::CFG_MOTION_POS, up);
		cfg_write(kf1d_pkg::CFG_MOTION_VEL, uv);
	endtask

	function automatic logic [31:0] small_signed(input int span);
		return 32'($signed($urandom_range(0, 2 * span)) - span);
	endfunction

	// next measurement: mostly a noisy track, sometimes arbitrary
	function automatic logic [31:0] next_meas();
		if ($urandom_range(99) < 15)
			return $urandom;
		if ($urandom_range(99) < 3)
			track_vel = longint'($signed(small_signed(32'h40000)));
		track_pos = track_pos + track_vel;
		if (track_pos > 64'sd1000000000 || track_pos < -64'sd1000000000)
			track_pos = 0;
		return 32'(track_pos + longint'($signed(small_signed(32'h20000))));
	endfunction

	task automatic test_field_extremes();
		send_meas(32'sh00000000);
		send_meas(32'sh7fffffff);
		send_meas(32'sh80000000);
		send_meas(32'shffffffff);
		send_meas(32'sh00010000);
		send_meas(32'shfffe0000);
		wait_idle();
	endtask

	task automatic test_register_extremes();
		// upper bits of the narrow registers must be dropped
		cfg_all(32'hffffffff, 32'hffffffff, 32'h7fffffff, 32'hffffffff,
			32'h7fffffff, 32'h7fffffff);
		send_meas(32'sh7fffffff);
		send_meas(32'sh80000000);
		wait_idle();
		cfg_all(32'h00000001, 32'h00000000, 32'h80000000, 32'h00000000,
			32'h80000000, 32'h80000000);
		send_meas(32'sh80000000);
		send_meas(32'sh7fffffff);
		wait_idle();
		// writes to unused indexes are ignored
		cfg_write(CFG_SPARE_LO, 32'h12345678);
		cfg_write(CFG_SPARE_HI, 32'hffffffff);
		send_meas(32'sh00000000);
		wait_idle();
	endtask

	task automatic test_nonpositive_innovation();
		// drive the covariance negative so that p00 + r stays below zero
		cfg_all(32'h00000000, 32'h00000000, 32'h80000000, 32'h00000000, 32'h0, 32'h0);
		repeat (6) send_meas($urandom);
		wait_idle();
		// pull the covariance back up
		cfg_all(32'h00010000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h0, 32'h0);
		repeat (4) send_meas($urandom);
		wait_idle();
	endtask

	task automatic test_tracking(input int phases, input int per_phase);
		int sel;
		for (int p = 0; p < phases; p++) begin
			sel = $urandom_range(9);
			if (sel == 0)
				cfg_all(32'h7fffffff, $urandom_range(0, 32'h7fffffff), $urandom,
					$urandom_range(0, 32'h7fffffff), $urandom, $urandom);
			else if (sel == 1)
				cfg_all(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
			else
				cfg_all($urandom_range(32'h100, 32'h100000), $urandom_range(0, 32'h4000),
					small_signed(32'h1000), $urandom_range(0, 32'h4000),
					($urandom_range(3) == 0) ? small_signed(32'h10000) : 32'h0,
					($urandom_range(3) == 0) ? small_signed(32'h1000) : 32'h0);
			// every third phase runs without any idling
			sender_idle_en = (p % 3 != 2);
			receiver_idle_en = (p % 3 != 2);
			repeat (per_phase) send_meas(next_meas());
			wait_idle();
		end
		sender_idle_en = 1'b1;
		receiver_idle_en = 1'b1;
	endtask

	task automatic test_output_backpressure();
		cfg_all(32'h00010000, 32'h00000100, 32'h00000000, 32'h00000100, 32'h0, 32'h0);
		hold_req = 3000;
		repeat (12) send_meas(next_meas());
		wait_idle();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_idx = kf1d_pkg::CFG_MEAS_NOISE_VAR;
		cfg_data = '0;
		meas_ch.valid = 1'b0;
		meas_ch.measurement = '0;
		n_errors = 0;
		n_meas = 0;
		n_estimates = 0;
		n_faults = 0;
		cycle_cnt = 0;
		hold_req = 0;
		sender_idle_en = 1'b1;
		receiver_idle_en = 1'b1;
		track_pos = 0;
		track_vel = 64'sd65536;
		est_pos = 0;
		est_vel = 0;
		est_var_pos = longint'(kf1d_pkg::VAR_RESET);
		est_cov_cross = 0;
		est_var_vel = longint'(kf1d_pkg::VAR_RESET);
		r_meas = longint'(kf1d_pkg::R_RESET);
		q_pos = 0;
		q_cross = 0;
		q_vel = 0;
		u_pos = 0;
		u_vel = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_extremes();
		test_register_extremes();
		test_nonpositive_innovation();
		test_output_backpressure();
		test_tracking(9, 125);
		test_nonpositive_innovation();
		test_tracking(1, 20);

		repeat (DRAIN_WAIT) @(posedge clk);
		$display("covered %0d measurements, %0d estimates checked, %0d with fault set",
			n_meas, n_estimates, n_faults);
		$display("register extremes, non-positive innovation, long output stall, %0d errors",
			n_errors);
		if (n_errors == 0 && expected_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> sim.f
+incdir+src
src/kf1d_pkg.sv
src/kf1d_if.sv
src/kf1d_ctrl.sv
src/kf1d_dp.sv
src/kalman_filter_1d_const_velocity_top.sv
src/kf1d_chk.sv
bench/tb_kalman_filter_1d_const_velocity_top.sv
